### src/s20_pkg.sv
// Salsa20 core package: payload types, constants and helper functions.
// No dependencies.
package s20_pkg;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int ROUND_W       = $clog2(DOUBLE_ROUNDS + 1);

    localparam logic [2:0] REG_KEY0  = 3'd0;
    localparam logic [2:0] REG_KEY1  = 3'd1;
    localparam logic [2:0] REG_KEY2  = 3'd2;
    localparam logic [2:0] REG_KEY3  = 3'd3;
    localparam logic [2:0] REG_NONCE = 3'd4;

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646E;
    localparam logic [31:0] SIGMA2 = 32'h79622D32;
    localparam logic [31:0] SIGMA3 = 32'h6B206574;

    typedef struct packed {
        logic [63:0] message_bytes;
        logic [3:0]  byte_count;
        logic        first_of_message;
    } s20_in_t;

    typedef struct packed {
        logic [63:0] cipher_bytes;
        logic [3:0]  bytes_valid;
    } s20_out_t;

    // word indexes {d, c, b, a} of each quarter-round of a double round
    localparam logic [15:0] QR_MAP [8] = '{
        16'hC840, 16'h1D95, 16'h62EA, 16'hB73F,
        16'h3210, 16'h4765, 16'h98BA, 16'hEDCF
    };

    function automatic logic [3:0] qr_idx(input logic [2:0] qsel, input logic [1:0] k);
        logic [15:0] m;
        m = QR_MAP[qsel];
        return m[{k, 2'b00} +: 4];
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] v, input int r);
        return (v << r) | (v >> (32 - r));
    endfunction

    function automatic logic [31:0] init_word(
        input logic [3:0]  idx,
        input logic [63:0] k0,
        input logic [63:0] k1,
        input logic [63:0] k2,
        input logic [63:0] k3,
        input logic [63:0] nonce,
        input logic [63:0] ctr
    );
        logic [31:0] w;
        case (idx)
            4'd0:    w = SIGMA0;
            4'd1:    w = k0[31:0];
            4'd2:    w = k0[63:32];
            4'd3:    w = k1[31:0];
            4'd4:    w = k1[63:32];
            4'd5:    w = SIGMA1;
            4'd6:    w = nonce[31:0];
            4'd7:    w = nonce[63:32];
            4'd8:    w = ctr[31:0];
            4'd9:    w = ctr[63:32];
            4'd10:   w = SIGMA2;
            4'd11:   w = k2[31:0];
            4'd12:   w = k2[63:32];
            4'd13:   w = k3[31:0];
            4'd14:   w = k3[63:32];
            default: w = SIGMA3;
        endcase
        return w;
    endfunction

endpackage

### src/s20_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module s20_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### src/salsa20_stream_cipher_core.sv
// Salsa20/20 stream cipher core: keystream sequencer and output stage.
// Depends on s20_pkg and s20_ram.
//
// Usage: write key_part_0..3 (index 0..3) and nonce (index 4) on the cfg
// port while idle. Input beats carry up to eight message bytes, a byte count
// and a first-of-message flag; output beats carry the XORed bytes (lanes past
// the count are zero) and a copy of the count. Each beat uses one 8-byte slot
// of a 64-byte keystream block.
// The working state and the keystream block sit in two 16x32 RAMs. One
// quarter-round unit does read 4 words, compute and write back 4 words.
// A beat that opens a block runs the 16 init writes, the rounds, the final
// add, the two keystream word reads and the output step; the other seven
// beats of a block take only the keystream reads and the output step.
// One beat is in work at a time; the next is taken as soon as the result
// sits in the output register.
// If the receiver stalls, the finished result waits in the sequencer until
// the output register frees up.
// Reset clears the counter, slot and keystream-valid flag; the config
// registers reset to zero. RAM contents are not cleared.
module salsa20_stream_cipher_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  s20_pkg::s20_in_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output s20_pkg::s20_out_t out_data,
    input  logic             cfg_write,
    input  logic [2:0]       cfg_index,
    input  logic [63:0]      cfg_data
);
    import s20_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_INIT, ST_QRD, ST_QCMP, ST_QWR, ST_FIN, ST_KREAD, ST_OUT
    } state_t;

    state_t             state_reg;
    logic [4:0]         step_reg;
    logic [2:0]         qsel_reg;
    logic [ROUND_W-1:0] round_reg;
    logic [31:0]        qw_reg [4];
    logic [63:0]        key0_reg, key1_reg, key2_reg, key3_reg, nonce_reg;
    logic [63:0]        ctr_reg;
    logic [2:0]         slot_reg;
    logic               ready_reg;
    logic [63:0]        msg_reg;
    logic [3:0]         cnt_reg;
    logic [63:0]        ks_reg;
    logic               out_valid_reg;
    s20_out_t           out_reg;

    logic        w_we, k_we;
    logic [3:0]  w_waddr, w_raddr, k_waddr, k_raddr;
    logic [31:0] w_wdata, w_rdata, k_wdata, k_rdata;
    logic [3:0]  fin_idx;
    logic [63:0] mask;
    logic        out_free;

    s20_ram #(.WIDTH(32), .DEPTH(16)) u_work (
        .clk(clk), .wr_en(w_we), .wr_addr(w_waddr), .wr_data(w_wdata),
        .rd_addr(w_raddr), .rd_data(w_rdata)
    );

    s20_ram #(.WIDTH(32), .DEPTH(16)) u_ks (
        .clk(clk), .wr_en(k_we), .wr_addr(k_waddr), .wr_data(k_wdata),
        .rd_addr(k_raddr), .rd_data(k_rdata)
    );

    assign fin_idx  = 4'(step_reg - 5'd1);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        w_we    = 1'b0;
        w_waddr = step_reg[3:0];
        w_wdata = init_word(step_reg[3:0], key0_reg, key1_reg, key2_reg, key3_reg,
                            nonce_reg, ctr_reg);
        w_raddr = step_reg[3:0];
        k_we    = 1'b0;
        k_waddr = fin_idx;
        k_wdata = w_rdata + init_word(fin_idx, key0_reg, key1_reg, key2_reg,
                                      key3_reg, nonce_reg, ctr_reg);
        k_raddr = {slot_reg, step_reg[0]};
        unique case (state_reg)
            ST_INIT:
            begin
                w_we = 1'b1;
            end
            ST_QRD:
            begin
                w_raddr = qr_idx(qsel_reg, step_reg[1:0]);
            end
            ST_QWR:
            begin
                w_we    = 1'b1;
                w_waddr = qr_idx(qsel_reg, step_reg[1:0]);
                w_wdata = qw_reg[step_reg[1:0]];
            end
            ST_FIN:
            begin
                k_we = (step_reg != 5'd0);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            mask[8*i +: 8] = (cnt_reg > 4'(i)) ? 8'hFF : 8'h00;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            qsel_reg      <= '0;
            round_reg     <= '0;
            key0_reg      <= '0;
            key1_reg      <= '0;
            key2_reg      <= '0;
            key3_reg      <= '0;
            nonce_reg     <= '0;
            ctr_reg       <= '0;
            slot_reg      <= '0;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_KEY0:  key0_reg  <= cfg_data;
                    REG_KEY1:  key1_reg  <= cfg_data;
                    REG_KEY2:  key2_reg  <= cfg_data;
                    REG_KEY3:  key3_reg  <= cfg_data;
                    REG_NONCE: nonce_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            // in ST_OUT the output stage reloads the flag itself
            if (out_valid_reg && out_ready && state_reg != ST_OUT)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= '0;
                    if (in_valid)
                    begin
                        msg_reg <= in_data.message_bytes;
                        cnt_reg <= in_data.byte_count;
                        if (in_data.first_of_message)
                        begin
                            ctr_reg   <= '0;
                            slot_reg  <= '0;
                            ready_reg <= 1'b0;
                        end
                        if (in_data.first_of_message || !ready_reg)
                        begin
                            state_reg <= ST_INIT;
                        end
                        else
                        begin
                            state_reg <= ST_KREAD;
                        end
                    end
                end
                ST_INIT:
                begin
                    if (step_reg == 5'd15)
                    begin
                        step_reg  <= '0;
                        qsel_reg  <= '0;
                        round_reg <= '0;
                        state_reg <= ST_QRD;
                    end
                    else
                    begin
                        step_reg <= step_reg + 5'd1;
                    end
                end
                ST_QRD:
                begin
                    if (step_reg != 5'd0)
                    begin
                        qw_reg[2'(step_reg - 5'd1)] <= w_rdata;
                    end
                    if (step_reg == 5'd4)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_QCMP;
                    end
                    else
                    begin
                        step_reg <= step_reg + 5'd1;
                    end
                end
                ST_QCMP:
                begin
                    case (step_reg[1:0])
                        2'd0: qw_reg[1] <= qw_reg[1] ^ rotl(qw_reg[0] + qw_reg[3], 7);
                        2'd1: qw_reg[2] <= qw_reg[2] ^ rotl(qw_reg[1] + qw_reg[0], 9);
                        2'd2: qw_reg[3] <= qw_reg[3] ^ rotl(qw_reg[2] + qw_reg[1], 13);
                        default: qw_reg[0] <= qw_reg[0] ^ rotl(qw_reg[3] + qw_reg[2], 18);
                    endcase
                    if (step_reg == 5'd3)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_QWR;
                    end
                    else
                    begin
                        step_reg <= step_reg + 5'd1;
                    end
                end
                ST_QWR:
                begin
                    if (step_reg == 5'd3)
                    begin
                        step_reg <= '0;
                        qsel_reg <= qsel_reg + 3'd1;
                        if (qsel_reg == 3'd7)
                        begin
                            if (round_reg == ROUND_W'(DOUBLE_ROUNDS - 1))
                            begin
                                state_reg <= ST_FIN;
                            end
                            else
                            begin
                                round_reg <= round_reg + 1'b1;
                                state_reg <= ST_QRD;
                            end
                        end
                        else
                        begin
                            state_reg <= ST_QRD;
                        end
                    end
                    else
                    begin
                        step_reg <= step_reg + 5'd1;
                    end
                end
                ST_FIN:
                begin
                    if (step_reg == 5'd16)
                    begin
                        step_reg  <= '0;
                        ready_reg <= 1'b1;
                        state_reg <= ST_KREAD;
                    end
                    else
                    begin
                        step_reg <= step_reg + 5'd1;
                    end
                end
                ST_KREAD:
                begin
                    if (step_reg == 5'd1)
                    begin
                        ks_reg[31:0] <= k_rdata;
                    end
                    if (step_reg == 5'd2)
                    begin
                        ks_reg[63:32] <= k_rdata;
                        state_reg     <= ST_OUT;
                    end
                    step_reg <= step_reg + 5'd1;
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg        <= 1'b1;
                        out_reg.cipher_bytes <= (msg_reg ^ ks_reg) & mask;
                        out_reg.bytes_valid  <= cnt_reg;
                        slot_reg             <= slot_reg + 3'd1;
                        if (slot_reg == 3'd7)
                        begin
                            ctr_reg   <= ctr_reg + 64'd1;
                            ready_reg <= 1'b0;
                        end
                        step_reg  <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else if (out_valid_reg && out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### bench/tb_salsa20_stream_cipher_core.sv
`timescale 1ns / 1ps
// Self-checking bench for salsa20_stream_cipher_core: directed table, then random messages.
// Holds its own Salsa20 keystream predictor; depends on s20_pkg and the core RTL.
module tb_salsa20_stream_cipher_core;
    import s20_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 3000;
    localparam int RANDOM_BEATS   = 680;

    typedef struct {
        s20_in_t  beat;
        bit       typed;
        s20_out_t want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    s20_in_t     in_data;
    logic        out_valid;
    logic        out_ready;
    s20_out_t    out_data;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    salsa20_stream_cipher_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [63:0] key_mirror [4];
    logic [63:0] nonce_mirror;
    logic [63:0] blk_ctr;
    logic [2:0]  slot;
    bit          ks_valid;
    logic [31:0] ks_words [16];
    logic [31:0] mix [16];

    s20_out_t    cipher_q [$];
    stim_row_t   table_rows [$];
    int          mismatches;
    int          beats_in;
    int          beats_out;
    int          idle_cycles;
    int          blocks_built;
    int          cfg_phases;
    int          hold_cnt;
    bit          hold_req;
    bit          quiet;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [31:0] rl(input logic [31:0] v, input int r);
        return (v << r) | (v >> (32 - r));
    endfunction

    function automatic void qround(input int a, input int b, input int c, input int d);
        mix[b] = mix[b] ^ rl(mix[a] + mix[d], 7);
        mix[c] = mix[c] ^ rl(mix[b] + mix[a], 9);
        mix[d] = mix[d] ^ rl(mix[c] + mix[b], 13);
        mix[a] = mix[a] ^ rl(mix[d] + mix[c], 18);
    endfunction

    function automatic void build_keystream();
        logic [31:0] start [16];
        start[0]  = 32'h61707865;
        start[1]  = key_mirror[0][31:0];
        start[2]  = key_mirror[0][63:32];
        start[3]  = key_mirror[1][31:0];
        start[4]  = key_mirror[1][63:32];
        start[5]  = 32'h3320646E;
        start[6]  = nonce_mirror[31:0];
        start[7]  = nonce_mirror[63:32];
        start[8]  = blk_ctr[31:0];
        start[9]  = blk_ctr[63:32];
        start[10] = 32'h79622D32;
        start[11] = key_mirror[2][31:0];
        start[12] = key_mirror[2][63:32];
        start[13] = key_mirror[3][31:0];
        start[14] = key_mirror[3][63:32];
        start[15] = 32'h6B206574;
        for (int i = 0; i < 16; i++)
            mix[i] = start[i];
        for (int r = 0; r < DOUBLE_ROUNDS; r++)
        begin
            qround(0, 4, 8, 12);
            qround(5, 9, 13, 1);
            qround(10, 14, 2, 6);
            qround(15, 3, 7, 11);
            qround(0, 1, 2, 3);
            qround(5, 6, 7, 4);
            qround(10, 11, 8, 9);
            qround(15, 12, 13, 14);
        end
        for (int i = 0; i < 16; i++)
            ks_words[i] = mix[i] + start[i];
        ks_valid = 1'b1;
        blocks_built++;
    endfunction

    function automatic s20_out_t encipher_beat(input s20_in_t b);
        s20_out_t    res;
        logic [63:0] ks;
        logic [63:0] lane_mask;
        if (b.first_of_message)
        begin
            blk_ctr  = '0;
            slot     = '0;
            ks_valid = 1'b0;
        end
        if (!ks_valid)
            build_keystream();
        ks = {ks_words[2 * slot + 1], ks_words[2 * slot]};
        if (b.byte_count >= 4'd8)
            lane_mask = '1;
        else
            lane_mask = (64'd1 << (8 * b.byte_count)) - 64'd1;
        res.cipher_bytes = (b.message_bytes ^ ks) & lane_mask;
        res.bytes_valid  = b.byte_count;
        slot = slot + 3'd1;
        if (slot == 3'd0)
        begin
            blk_ctr  = blk_ctr + 64'd1;
            ks_valid = 1'b0;
        end
        return res;
    endfunction

    function automatic s20_in_t mk_beat(input logic [63:0] m, input int n, input bit f);
        s20_in_t b;
        b.message_bytes    = m;
        b.byte_count       = n[3:0];
        b.first_of_message = f;
        return b;
    endfunction

    function automatic void add_row(input s20_in_t b, input bit typed, input s20_out_t w);
        stim_row_t row;
        row.beat  = b;
        row.typed = typed;
        row.want  = w;
        table_rows.push_back(row);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic write_config(input logic [63:0] k0, input logic [63:0] k1,
                                input logic [63:0] k2, input logic [63:0] k3,
                                input logic [63:0] nv);
        logic [63:0] vals [5];
        logic [2:0]  idx  [5];
        vals = '{k0, k1, k2, k3, nv};
        idx  = '{REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3, REG_NONCE};
        for (int i = 0; i < 5; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            if (i < 4)
                key_mirror[i] = vals[i];
            else
                nonce_mirror = vals[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        cfg_phases++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (cipher_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // valid stays up between back-to-back beats; lowered only for a gap
    task automatic send_beat(input s20_in_t b, input bit typed, input s20_out_t w);
        s20_out_t pred;
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pred = encipher_beat(b);
        cipher_q.push_back(typed ? w : pred);
        beats_in++;
        if (!quiet && $urandom_range(99) < 24)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // receiver and checker
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                beats_out++;
                if (cipher_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected beat %h/%0d", out_data.cipher_bytes,
                                 out_data.bytes_valid);
                end
                else
                begin
                    s20_out_t w;
                    w = cipher_q.pop_front();
                    if (w.cipher_bytes !== out_data.cipher_bytes ||
                        w.bytes_valid !== out_data.bytes_valid)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: beat %0d exp %h/%0d got %h/%0d", beats_out,
                                     w.cipher_bytes, w.bytes_valid,
                                     out_data.cipher_bytes, out_data.bytes_valid);
                    end
                end
            end
            if (hold_req && hold_cnt == 0)
            begin
                hold_cnt = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 24);
        end
    end

    // watchdog on handshake progress
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TIMEOUT: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        s20_out_t zero_out;
        s20_out_t none;
        int       n;
        int       len;
        bit       noise;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        out_ready    = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        mismatches   = 0;
        beats_in     = 0;
        beats_out    = 0;
        idle_cycles  = 0;
        blocks_built = 0;
        cfg_phases   = 0;
        hold_cnt     = 0;
        hold_req     = 1'b0;
        quiet        = 1'b0;
        for (int i = 0; i < 4; i++)
            key_mirror[i] = '0;
        nonce_mirror = '0;
        blk_ctr      = '0;
        slot         = '0;
        ks_valid     = 1'b0;
        zero_out     = '0;
        none         = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset keys, no first flag, counts 0..15, boundary, mid-block first
        add_row(mk_beat('0, 8, 1'b0), 1'b0, none);
        add_row(mk_beat('1, 8, 1'b0), 1'b0, none);
        add_row(mk_beat(64'hFFFF_FFFF_FFFF_FFFF, 0, 1'b0), 1'b1, zero_out);
        for (int c = 1; c <= 7; c++)
            add_row(mk_beat(64'hA5A5_5A5A_0F0F_F0F0, c, 1'b0), 1'b0, none);
        for (int c = 9; c <= 15; c++)
            add_row(mk_beat(64'h0123_4567_89AB_CDEF, c, 1'b0), 1'b0, none);
        add_row(mk_beat('1, 8, 1'b1), 1'b0, none);
        add_row(mk_beat('0, 3, 1'b0), 1'b0, none);
        add_row(mk_beat(64'h8000_0000_0000_0001, 8, 1'b1), 1'b0, none);
        foreach (table_rows[i])
            send_beat(table_rows[i].beat, table_rows[i].typed, table_rows[i].want);
        drain();

        write_config('1, '1, '1, '1, '1);
        for (int i = 0; i < 10; i++)
            send_beat(mk_beat(rand64(), 8, i == 0), 1'b0, none);
        drain();
        write_config(64'h0706050403020100, 64'h0F0E0D0C0B0A0908,
                     64'h1716151413121110, 64'h1F1E1D1C1B1A1918, 64'h0706050403020100);

        n = 0;
        while (n < RANDOM_BEATS)
        begin
            quiet = (n >= 300 && n < 400);
            if (n >= 150 && n < 200 && hold_cnt == 0 && cfg_phases < 4)
                hold_req = 1'b1;
            noise = ($urandom_range(9) == 0);
            len   = noise ? $urandom_range(1, 4) : $urandom_range(1, 24);
            for (int i = 0; i < len; i++)
            begin
                s20_in_t b;
                if (noise)
                    b = mk_beat(rand64(), $urandom_range(0, 15), $urandom_range(1));
                else if (i == len - 1 && $urandom_range(1) == 1)
                    b = mk_beat(rand64(), $urandom_range(1, 7), i == 0);
                else
                    b = mk_beat(rand64(), 8, i == 0);
                send_beat(b, 1'b0, none);
                n++;
            end
            if (n % 170 < len && n < RANDOM_BEATS)
            begin
                drain();
                write_config(rand64(), rand64(), rand64(), rand64(), rand64());
            end
        end
        drain();
        repeat (30) @(posedge clk);

        $display("Covered %0d beats in, %0d out, %0d keystream blocks, %0d key/nonce settings,",
                 beats_in, beats_out, blocks_built, cfg_phases + 1);
        $display("with random gaps, a long output hold-off and mid-message key changes.");
        if (mismatches == 0 && cipher_q.size() == 0)
            $display("*** PASSED ***");
        else
        begin
            $display("%0d mismatches, %0d beats missing", mismatches, cipher_q.size());
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

### filelist.f
src/s20_pkg.sv
src/s20_ram.sv
src/salsa20_stream_cipher_core.sv
bench/tb_salsa20_stream_cipher_core.sv
